// ----- rtl/signed_int_to_decimal_ascii_top_assert.svh -----
// assertion macros for the integer to decimal text block
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_ASSERT_SVH

// checked only outside reset
`define SIDA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SIDA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sida_pkg.sv -----
package sida_pkg;

	localparam int unsigned SIDA_DIGITS  = 10;
	localparam int unsigned SIDA_DIGIT_W = 4;
	localparam int unsigned SIDA_BCD_W   = SIDA_DIGITS * SIDA_DIGIT_W;

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	// converted number handed from the converter to the serializer
	typedef struct packed {
		logic                  neg;
		logic [SIDA_BCD_W-1:0] digits;
	} sida_bcd_t;

endpackage

// ----- rtl/sida_bin2bcd.sv -----
module sida_bin2bcd
	import sida_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [31:0]      value,
	output logic             out_valid,
	input  logic             out_take,
	output sida_bcd_t        out_word
);

	localparam int unsigned WW = SIDA_BCD_W + 32;

	// eight shift-add-3 steps over the packed {bcd, binary} word
	function automatic logic [WW-1:0] dabble8(input logic [WW-1:0] w);
		logic [WW-1:0] t;
		t = w;
		for (int s = 0; s < 8; s++) begin
			for (int d = 0; d < SIDA_DIGITS; d++) begin
				if (t[32 + SIDA_DIGIT_W*d +: SIDA_DIGIT_W] >= 4'd5)
					t[32 + SIDA_DIGIT_W*d +: SIDA_DIGIT_W] =
						t[32 + SIDA_DIGIT_W*d +: SIDA_DIGIT_W] + 4'd3;
			end
			t = {t[WW-2:0], 1'b0};
		end
		return t;
	endfunction

	logic          v_s1, v_s2, v_s3, v_s4, v_s5;
	logic          neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [WW-1:0] wd_s1, wd_s2, wd_s3, wd_s4, wd_s5;
	logic          rdy1, rdy2, rdy3, rdy4, rdy5;
	logic [31:0]   mag;

	assign mag = value[31] ? (~value + 32'd1) : value;

	// a stage moves when it is empty or the one after it moves
	assign rdy5 = !v_s5 || out_take;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			neg_s1 <= value[31];
			wd_s1  <= {{SIDA_BCD_W{1'b0}}, mag};
		end
		if (rdy2 && v_s1) begin
			neg_s2 <= neg_s1;
			wd_s2  <= dabble8(wd_s1);
		end
		if (rdy3 && v_s2) begin
			neg_s3 <= neg_s2;
			wd_s3  <= dabble8(wd_s2);
		end
		if (rdy4 && v_s3) begin
			neg_s4 <= neg_s3;
			wd_s4  <= dabble8(wd_s3);
		end
		if (rdy5 && v_s4) begin
			neg_s5 <= neg_s4;
			wd_s5  <= dabble8(wd_s4);
		end
	end

	assign out_valid       = v_s5;
	assign out_word.neg    = neg_s5;
	assign out_word.digits = wd_s5[WW-1:32];

endmodule

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
// signed 32-bit integer to decimal ascii text. each word on the value channel
// is one two's-complement number; the char channel returns its text one
// character per word: a leading '-' for negative numbers, then the decimal
// digits most significant first with no leading zeros ("0" for zero), with
// is_last set on the final character. the most negative number gives the
// eleven characters "-2147483648". a text is 1 to 11 characters long and
// leaves through the single-character output port one character per word.
// a number passes a five-stage binary to bcd pipeline (input register, then
// four stages of eight shift-add-3 steps each) before the serializer, which
// offers the first character once it has loaded the number from the last
// stage. the pipeline keeps taking numbers while the serializer is busy until
// its five stages are full, and the serializer loads the next number on the
// same edge that its last character leaves, so there is no gap between texts
// when the next number is waiting.
module signed_int_to_decimal_ascii_top
	import sida_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// number in
	input  logic        value_valid,
	output logic        value_stall,
	input  logic [31:0] value,
	// characters out
	output logic        char_valid,
	input  logic        char_stall,
	output logic [7:0]  char_code,
	output logic        is_last
);

	sida_bcd_t             cv_word;
	logic                  cv_valid;
	logic                  cv_take;

	// serializer state
	logic                  busy_q;
	logic                  neg_q;
	logic [SIDA_BCD_W-1:0] sh_q;
	logic [3:0]            cnt_q;

	logic                  char_acc;
	logic                  done_now;
	logic [3:0]            lz;
	logic                  found;

	sida_bin2bcd u_bin2bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (value_valid),
		.in_stall (value_stall),
		.value    (value),
		.out_valid(cv_valid),
		.out_take (cv_take),
		.out_word (cv_word)
	);

	// count of leading zero digits, the units digit always stays
	always_comb begin
		lz    = 4'd0;
		found = 1'b0;
		for (int i = SIDA_DIGITS - 1; i > 0; i--) begin
			if (!found && cv_word.digits[SIDA_DIGIT_W*i +: SIDA_DIGIT_W] == 4'd0)
				lz = lz + 4'd1;
			else
				found = 1'b1;
		end
	end

	assign char_acc = busy_q && !char_stall;
	// the word that leaves now is the last one of this number
	assign done_now = char_acc && !neg_q && cnt_q == 4'd1;
	assign cv_take  = cv_valid && (!busy_q || done_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			if (cv_take) begin
				busy_q <= 1'b1;
				neg_q  <= cv_word.neg;
				cnt_q  <= 4'(SIDA_DIGITS) - lz;
			end else if (done_now) begin
				busy_q <= 1'b0;
			end else if (char_acc) begin
				if (neg_q)
					neg_q <= 1'b0;
				else
					cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	// digits left aligned, the next one to send sits in the top nibble
	always_ff @(posedge clk) begin
		if (cv_take)
			sh_q <= cv_word.digits << {lz, 2'b00};
		else if (char_acc && !neg_q)
			sh_q <= {sh_q[SIDA_BCD_W-SIDA_DIGIT_W-1:0], {SIDA_DIGIT_W{1'b0}}};
	end

	assign char_valid = busy_q;
	assign char_code  = neg_q ? ASCII_MINUS
		: ASCII_ZERO + {4'd0, sh_q[SIDA_BCD_W-1 -: SIDA_DIGIT_W]};
	assign is_last    = !neg_q && cnt_q == 4'd1;

endmodule

// ----- rtl/sida_checker.sv -----
`include "signed_int_to_decimal_ascii_top_assert.svh"

module sida_checker
	import sida_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        char_valid,
	input logic        char_stall,
	input logic [7:0]  char_code,
	input logic        is_last
);

	`SIDA_ASSERT(a_valid_holds, char_valid && char_stall |=> char_valid, "char word dropped while stalled")
	`SIDA_ASSERT(a_word_holds, char_valid && char_stall |=> $stable(char_code) && $stable(is_last), "char word changed while stalled")
	`SIDA_ASSERT(a_minus_not_last, char_valid && char_code == ASCII_MINUS |-> !is_last, "text ends in a minus")
	`SIDA_ASSERT(a_digit_after_minus, char_valid && !char_stall && char_code == ASCII_MINUS |=> char_valid && char_code != ASCII_MINUS, "no digit right after minus")
	`SIDA_ASSERT_ALWAYS(a_code_legal, char_valid && arst_n |-> char_code == ASCII_MINUS || (char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + 8'd9), "char code outside minus and digits")

endmodule

bind signed_int_to_decimal_ascii_top sida_checker u_sida_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.char_valid(char_valid),
	.char_stall(char_stall),
	.char_code (char_code),
	.is_last   (is_last)
);
